### hw/rtl/pss_pkg.sv
// ---------------------------------------------------------------------------
// pss_pkg: shared types and constants of the phrase step sequencer core
// Event codes, register indexes, step word layout and result item layout.
// ---------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  // Default sizes of the pattern store.
  localparam int DEF_MAX_STEPS    = 16;
  localparam int DEF_NUM_PATTERNS = 16;

  // The song always has sixteen entries.
  localparam int SONG_LEN = 16;
  localparam int PHRASE_W = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT   = 2'd0,
    REG_PHRASE_COUNT = 2'd1
  } cfg_reg_e;

  // Event codes carried by an input word.
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_RUN      = 4'd1,
    CMD_LEFT     = 4'd2,
    CMD_RIGHT    = 4'd3,
    CMD_OCT_UP   = 4'd4,
    CMD_OCT_DOWN = 4'd5,
    CMD_GATE1    = 4'd6,
    CMD_GATE2    = 4'd7,
    CMD_SLIDE    = 4'd8,
    CMD_CLOCK    = 4'd9,
    CMD_RESET    = 4'd10
  } cmd_e;

  // Knob moves larger than this are treated as jumps and edit nothing.
  localparam logic signed [16:0] KNOB_JUMP = 17'sd2;

  // Note range in twelfths and the octave move limits.
  localparam logic signed [6:0] OCTAVE_STEP  = 7'sd12;
  localparam logic signed [6:0] NOTE_UP_MAX  = 7'sd35;
  localparam logic signed [6:0] NOTE_DN_MIN  = -7'sd24;
  localparam logic signed [6:0] NOTE_OFFSET  = 7'sd36;

  // Octave number is (note + 36) / 12, done as a multiply by 43 and a shift
  // by 9, which is exact over 0..83.
  localparam int          OCT_RECIP = 43;
  localparam int          OCT_SHIFT = 9;
  localparam logic [2:0]  OCTAVE_NONE = 3'd7;

  // One step of a pattern as held in the step memory.
  typedef struct packed {
    logic signed [6:0] note;
    logic              gate1;
    logic              gate2;
    logic              slide;
  } step_word_t;

  localparam step_word_t CLEAR_WORD = '{note: 7'sd0, gate1: 1'b1, gate2: 1'b1,
                                        slide: 1'b1};

  // Work handed from the control stage to the step stage.
  typedef struct packed {
    logic [3:0] cmd;
    logic       pattern_mode;
    logic [3:0] edit_cursor;
    logic [3:0] run_cursor;
    logic       running_now;
    logic [3:0] shown_number;
  } cell_req_t;

  // One result word.
  typedef struct packed {
    logic [3:0]        edit_cursor;
    logic [3:0]        run_cursor;
    logic              running_now;
    logic [2:0]        octave_light;
    logic              gate_one_led;
    logic              gate_two_led;
    logic              slide_led;
    logic [3:0]        shown_number;
    logic signed [6:0] edit_note;
  } out_item_t;

  // Output queue sizing.
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

endpackage

`default_nettype wire

### hw/rtl/pss_in_if.sv
// ---------------------------------------------------------------------------
// pss_in_if: event channel
// Valid/ready channel carrying one event word per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface pss_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic               pattern_mode;
  logic signed [15:0] knob_position;

  modport source (output valid, output cmd, output pattern_mode,
                  output knob_position, input ready);
  modport sink   (input valid, input cmd, input pattern_mode,
                  input knob_position, output ready);
endinterface

`default_nettype wire

### hw/rtl/pss_out_if.sv
// ---------------------------------------------------------------------------
// pss_out_if: result channel
// Valid/ready channel carrying cursor and indicator values per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface pss_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        edit_cursor;
  logic [3:0]        run_cursor;
  logic              running_now;
  logic [2:0]        octave_light;
  logic              gate_one_led;
  logic              gate_two_led;
  logic              slide_led;
  logic [3:0]        shown_number;
  logic signed [6:0] edit_note;

  modport source (output valid, output edit_cursor, output run_cursor,
                  output running_now, output octave_light, output gate_one_led,
                  output gate_two_led, output slide_led, output shown_number,
                  output edit_note, input ready);
  modport sink   (input valid, input edit_cursor, input run_cursor,
                  input running_now, input octave_light, input gate_one_led,
                  input gate_two_led, input slide_led, input shown_number,
                  input edit_note, output ready);
endinterface

`default_nettype wire

### hw/rtl/pss_cfg_if.sv
// ---------------------------------------------------------------------------
// pss_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface pss_cfg_if import pss_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/pss_ram.sv
// ---------------------------------------------------------------------------
// pss_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered, read-first.
// ---------------------------------------------------------------------------
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/pss_ctrl.sv
// ---------------------------------------------------------------------------
// pss_ctrl: cursor, run and knob control stage
// Holds the count registers, cursors, run state, selected pattern and song
// table, updates them per accepted event or register write and issues the step memory read.
// ---------------------------------------------------------------------------
`default_nettype none

module pss_ctrl import pss_pkg::*; #(
  parameter int MAX_STEPS    = DEF_MAX_STEPS,
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_accept,
  input  wire logic [3:0]               in_cmd,
  input  wire logic                     in_pattern_mode,
  input  wire logic signed [15:0]       in_knob,
  input  wire logic                     cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output      logic [$clog2(NUM_PATTERNS*MAX_STEPS)-1:0] rd_addr,
  output      logic [$clog2(NUM_PATTERNS*MAX_STEPS)-1:0] sb_addr,
  output      cell_req_t                sb_req,
  output      logic                     sb_valid
);

  localparam int SW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int PW = $clog2(NUM_PATTERNS);
  localparam int AW = $clog2(NUM_PATTERNS * MAX_STEPS);
  localparam logic signed [PW+1:0] PAT_MAX = (PW+2)'(NUM_PATTERNS - 1);

  // Configuration and control state.
  logic [CFG_DATA_W-1:0] step_count_r;
  logic [CFG_DATA_W-1:0] phrase_count_r;
  logic                  run_flag_r, run_flag_nxt;
  logic [SW-1:0]         edit_step_r, edit_step_nxt;
  logic [SW-1:0]         run_step_r, run_step_nxt;
  logic [SW-1:0]         sip_r, sip_nxt;
  logic [PHRASE_W-1:0]   edit_phrase_r, edit_phrase_nxt;
  logic [PHRASE_W-1:0]   run_phrase_r, run_phrase_nxt;
  logic [PW-1:0]         sel_pat_r, sel_pat_nxt;
  logic [PW-1:0]         song_r [SONG_LEN];
  logic [PW-1:0]         song_nxt [SONG_LEN];
  logic signed [15:0]    last_knob_r;

  // Stage register toward the step stage.
  cell_req_t             sb_req_r, req_nxt;
  logic [AW-1:0]         sb_addr_r, addr_nxt;
  logic                  sb_valid_r;

  // Working values.
  logic [CW:0]           steps_x;
  logic [CFG_DATA_W-1:0] phrases_x;
  logic [CW:0]           idx_x, run_inc, sip_inc;
  logic [CFG_DATA_W-1:0] ph_x, rp_inc;
  logic [SW-1:0]         step_left, step_right;
  logic [PHRASE_W-1:0]   phrase_left, phrase_right;
  logic [PHRASE_W-1:0]   mid_phrase;
  logic signed [16:0]    knob_diff;
  logic                  knob_edit;
  logic [PW-1:0]         knob_cur, knob_val, song_entry;
  logic signed [PW+1:0]  knob_sum;

  // Effective counts: zero reads as one, large values saturate.
  always_comb begin
    if (step_count_r == '0) begin
      steps_x = (CW+1)'(1);
    end else if (32'(step_count_r) > 32'(MAX_STEPS)) begin
      steps_x = (CW+1)'(MAX_STEPS);
    end else begin
      steps_x = (CW+1)'(step_count_r);
    end
    if (phrase_count_r == '0) begin
      phrases_x = CFG_DATA_W'(1);
    end else if (32'(phrase_count_r) > 32'(SONG_LEN)) begin
      phrases_x = CFG_DATA_W'(SONG_LEN);
    end else begin
      phrases_x = phrase_count_r;
    end
  end

  // Cursor moves with wraparound within the count.
  always_comb begin
    idx_x = (CW+1)'(edit_step_r);
    ph_x  = CFG_DATA_W'(edit_phrase_r);
    if (idx_x == '0 || idx_x > steps_x) begin
      step_left = SW'(steps_x - (CW+1)'(1));
    end else begin
      step_left = SW'(idx_x - (CW+1)'(1));
    end
    if (idx_x + (CW+1)'(1) >= steps_x) begin
      step_right = '0;
    end else begin
      step_right = SW'(idx_x + (CW+1)'(1));
    end
    if (ph_x == '0 || ph_x > phrases_x) begin
      phrase_left = PHRASE_W'(phrases_x - CFG_DATA_W'(1));
    end else begin
      phrase_left = PHRASE_W'(ph_x - CFG_DATA_W'(1));
    end
    if (ph_x + CFG_DATA_W'(1) >= phrases_x) begin
      phrase_right = '0;
    end else begin
      phrase_right = PHRASE_W'(ph_x + CFG_DATA_W'(1));
    end
    run_inc = (CW+1)'(run_step_r) + (CW+1)'(1);
    sip_inc = (CW+1)'(sip_r) + (CW+1)'(1);
    rp_inc  = CFG_DATA_W'(run_phrase_r) + CFG_DATA_W'(1);
  end

  // Next state for one event.
  always_comb begin
    run_flag_nxt    = run_flag_r;
    edit_step_nxt   = edit_step_r;
    run_step_nxt    = run_step_r;
    sip_nxt         = sip_r;
    edit_phrase_nxt = edit_phrase_r;
    run_phrase_nxt  = run_phrase_r;
    sel_pat_nxt     = sel_pat_r;
    song_nxt        = song_r;

    // Run toggle and cursor moves come first.
    case (in_cmd)
      CMD_RUN: begin
        run_flag_nxt = !run_flag_r;
      end
      CMD_LEFT: begin
        if (in_pattern_mode) begin
          edit_step_nxt = step_left;
        end else begin
          edit_phrase_nxt = phrase_left;
        end
      end
      CMD_RIGHT: begin
        if (in_pattern_mode) begin
          edit_step_nxt = step_right;
        end else begin
          edit_phrase_nxt = phrase_right;
        end
      end
      default: ;
    endcase
    mid_phrase = edit_phrase_nxt;

    // Small knob moves edit the pattern number or the song entry.
    knob_diff  = $signed({in_knob[15], in_knob}) - $signed({last_knob_r[15], last_knob_r});
    knob_edit  = (knob_diff != '0) && (knob_diff >= -KNOB_JUMP) && (knob_diff <= KNOB_JUMP);
    knob_cur   = in_pattern_mode ? sel_pat_r : song_r[mid_phrase];
    knob_sum   = $signed({2'b00, knob_cur}) + $signed(knob_diff[PW+1:0]);
    if (knob_sum < 0) begin
      knob_val = '0;
    end else if (knob_sum > PAT_MAX) begin
      knob_val = PW'(PAT_MAX);
    end else begin
      knob_val = PW'(knob_sum);
    end
    song_entry = song_r[mid_phrase];
    if (knob_edit) begin
      if (in_pattern_mode) begin
        sel_pat_nxt = knob_val;
      end else begin
        song_nxt[mid_phrase] = knob_val;
        song_entry           = knob_val;
      end
    end

    // Clock advance and cursor reset.
    case (in_cmd)
      CMD_CLOCK: begin
        if (run_flag_r) begin
          if (in_pattern_mode) begin
            run_step_nxt = (run_inc >= steps_x) ? '0 : SW'(run_inc);
          end else if (sip_inc >= steps_x) begin
            sip_nxt        = '0;
            run_phrase_nxt = (rp_inc >= phrases_x) ? '0 : PHRASE_W'(rp_inc);
          end else begin
            sip_nxt = SW'(sip_inc);
          end
        end
      end
      CMD_RESET: begin
        edit_step_nxt   = '0;
        run_step_nxt    = '0;
        edit_phrase_nxt = '0;
        run_phrase_nxt  = '0;
      end
      default: ;
    endcase

    // Work for the step stage; the song entry at phrase zero is unedited
    // when a cursor reset moved the edit phrase away from the knob edit.
    req_nxt.cmd          = in_cmd;
    req_nxt.pattern_mode = in_pattern_mode;
    req_nxt.edit_cursor  = in_pattern_mode ? 4'(edit_step_nxt) : edit_phrase_nxt;
    req_nxt.run_cursor   = in_pattern_mode ? 4'(run_step_nxt) : run_phrase_nxt;
    req_nxt.running_now  = run_flag_nxt;
    if (in_pattern_mode) begin
      req_nxt.shown_number = 4'(sel_pat_nxt);
    end else if (edit_phrase_nxt == mid_phrase) begin
      req_nxt.shown_number = 4'(song_entry);
    end else begin
      req_nxt.shown_number = 4'(song_r[0]);
    end
    addr_nxt = AW'(sel_pat_nxt) * AW'(MAX_STEPS) + AW'(edit_step_nxt);
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r   <= CFG_DATA_W'(16);
      phrase_count_r <= CFG_DATA_W'(1);
      run_flag_r     <= 1'b0;
      edit_step_r    <= '0;
      run_step_r     <= '0;
      sip_r          <= '0;
      edit_phrase_r  <= '0;
      run_phrase_r   <= '0;
      sel_pat_r      <= '0;
      last_knob_r    <= '0;
      sb_valid_r     <= 1'b0;
      for (int i = 0; i < SONG_LEN; i++) begin
        song_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_STEP_COUNT:   step_count_r   <= cfg_data;
          REG_PHRASE_COUNT: phrase_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        run_flag_r    <= run_flag_nxt;
        edit_step_r   <= edit_step_nxt;
        run_step_r    <= run_step_nxt;
        sip_r         <= sip_nxt;
        edit_phrase_r <= edit_phrase_nxt;
        run_phrase_r  <= run_phrase_nxt;
        sel_pat_r     <= sel_pat_nxt;
        last_knob_r   <= in_knob;
        song_r        <= song_nxt;
      end
      sb_valid_r <= in_accept;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sb_req_r  <= req_nxt;
      sb_addr_r <= addr_nxt;
    end
  end

  assign rd_addr  = addr_nxt;
  assign sb_addr  = sb_addr_r;
  assign sb_req   = sb_req_r;
  assign sb_valid = sb_valid_r;

endmodule

`default_nettype wire

### hw/rtl/pss_cell.sv
// ---------------------------------------------------------------------------
// pss_cell: step memory stage
// Owns the step memory, clears it after reset, applies octave, gate and
// slide edits to the edited step and forms the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module pss_cell import pss_pkg::*; #(
  parameter int MAX_STEPS    = DEF_MAX_STEPS,
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [$clog2(NUM_PATTERNS*MAX_STEPS)-1:0] rd_addr,
  input  wire logic [$clog2(NUM_PATTERNS*MAX_STEPS)-1:0] req_addr,
  input  wire cell_req_t                req,
  input  wire logic                     req_valid,
  output      logic                     clr_busy,
  output      out_item_t                item
);

  localparam int DEPTH = NUM_PATTERNS * MAX_STEPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $bits(step_word_t);

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  step_word_t    fwd_word_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [WW-1:0] rd_data;

  step_word_t    cur, upd;
  logic [6:0]    oct_in;
  logic [11:0]   oct_prod;

  pss_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clearing pass after reset, one step word per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // The previous cycle's write is not yet in the read data; forward it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= req_addr;
    fwd_word_r <= upd;
  end

  // Edit the step word.
  always_comb begin
    cur = (fwd_valid_r && fwd_addr_r == req_addr) ? fwd_word_r : step_word_t'(rd_data);
    upd = cur;
    if (req.pattern_mode) begin
      case (req.cmd)
        CMD_OCT_UP: begin
          if (cur.note <= NOTE_UP_MAX) begin
            upd.note = cur.note + OCTAVE_STEP;
          end
        end
        CMD_OCT_DOWN: begin
          if (cur.note >= NOTE_DN_MIN) begin
            upd.note = cur.note - OCTAVE_STEP;
          end
        end
        CMD_GATE1: upd.gate1 = !cur.gate1;
        CMD_GATE2: upd.gate2 = !cur.gate2;
        CMD_SLIDE: upd.slide = !cur.slide;
        default: ;
      endcase
    end
  end

  // Write port: clearing pass first, then the edited step.
  assign wr_en   = clr_busy_r || req_valid;
  assign wr_addr = clr_busy_r ? clr_addr_r : req_addr;
  assign wr_data = clr_busy_r ? WW'(CLEAR_WORD) : WW'(upd);

  // Result word; the octave is (note + 36) / 12 by reciprocal multiply.
  always_comb begin
    oct_in   = 7'(upd.note + NOTE_OFFSET);
    oct_prod = 12'(oct_in) * 12'(OCT_RECIP);

    item.edit_cursor  = req.edit_cursor;
    item.run_cursor   = req.run_cursor;
    item.running_now  = req.running_now;
    item.octave_light = req.pattern_mode ? oct_prod[OCT_SHIFT +: 3] : OCTAVE_NONE;
    item.gate_one_led = req.pattern_mode && upd.gate1;
    item.gate_two_led = req.pattern_mode && upd.gate2;
    item.slide_led    = req.pattern_mode && upd.slide;
    item.shown_number = req.shown_number;
    item.edit_note    = upd.note;
  end

  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

### hw/rtl/pss_outq.sv
// ---------------------------------------------------------------------------
// pss_outq: result queue
// Small first-in first-out buffer that decouples the result channel from
// the processing stages.
// ---------------------------------------------------------------------------
`default_nettype none

module pss_outq import pss_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire out_item_t             push_item,
  input  wire logic                  pop,
  output      out_item_t             head,
  output      logic [OUTQ_CNT_W-1:0] count
);

  out_item_t               q_mem_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]   cnt_r;

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + OUTQ_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + OUTQ_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - OUTQ_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head  = q_mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

### hw/rtl/phrase_step_sequencer_core_unit.sv
// ---------------------------------------------------------------------------
// phrase_step_sequencer_core_unit: pattern and song step sequencer control
// Takes one event word per transfer and returns one result word with the
// cursors, run state and indicators after that event.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch   event words (cmd, pattern_mode, knob_position), valid/ready.
//   out_ch  result words, one per event word, in order, valid/ready.
//   cfg_ch  register writes: index 0 step count, index 1 phrase count.
//           Always ready; write only while no events are in flight.
// Path: an accepted event is registered into the control stage, which issues
//   the step memory read; the step stage then edits the step, writes it back
//   and enters the result in the queue, from which out_ch offers it.
// Throughput: one event per cycle while the result queue has room, limited by
//   the single read-modify-write of the step memory per event.
// Reset: after rst_n rises, the step memory is cleared one word per cycle,
//   all NUM_PATTERNS * MAX_STEPS words (256 at default sizes); in_ch is not
//   ready during that pass.
// Stall: a three-word result queue holds finished results; in_ch stays
//   ready while the queue plus the word in flight leave room for one more.
// ---------------------------------------------------------------------------
`default_nettype none

module phrase_step_sequencer_core_unit import pss_pkg::*; #(
  parameter int MAX_STEPS    = DEF_MAX_STEPS,
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pss_in_if.sink      in_ch,
  pss_out_if.source   out_ch,
  pss_cfg_if.sink     cfg_ch
);

  localparam int AW = $clog2(NUM_PATTERNS * MAX_STEPS);

  logic                  in_ready;
  logic                  in_accept;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         sb_addr;
  cell_req_t             sb_req;
  logic                  sb_valid;
  logic                  clr_busy;
  out_item_t             cell_item;
  out_item_t             head;
  logic [OUTQ_CNT_W-1:0] q_cnt;
  logic                  q_pop;

  // Accept while the queue can absorb this word and the one in flight.
  assign in_ready  = !clr_busy &&
                     ((OUTQ_CNT_W+1)'(q_cnt) + (OUTQ_CNT_W+1)'(sb_valid)
                      < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  pss_ctrl #(
    .MAX_STEPS    (MAX_STEPS),
    .NUM_PATTERNS (NUM_PATTERNS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_cmd          (in_ch.cmd),
    .in_pattern_mode (in_ch.pattern_mode),
    .in_knob         (in_ch.knob_position),
    .cfg_wr          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .rd_addr         (rd_addr),
    .sb_addr         (sb_addr),
    .sb_req          (sb_req),
    .sb_valid        (sb_valid)
  );

  pss_cell #(
    .MAX_STEPS    (MAX_STEPS),
    .NUM_PATTERNS (NUM_PATTERNS)
  ) u_cell (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .req_addr  (sb_addr),
    .req       (sb_req),
    .req_valid (sb_valid),
    .clr_busy  (clr_busy),
    .item      (cell_item)
  );

  pss_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (sb_valid),
    .push_item (cell_item),
    .pop       (q_pop),
    .head      (head),
    .count     (q_cnt)
  );

  // Result channel.
  assign out_ch.valid        = (q_cnt != '0);
  assign q_pop               = out_ch.valid && out_ch.ready;
  assign out_ch.edit_cursor  = head.edit_cursor;
  assign out_ch.run_cursor   = head.run_cursor;
  assign out_ch.running_now  = head.running_now;
  assign out_ch.octave_light = head.octave_light;
  assign out_ch.gate_one_led = head.gate_one_led;
  assign out_ch.gate_two_led = head.gate_two_led;
  assign out_ch.slide_led    = head.slide_led;
  assign out_ch.shown_number = head.shown_number;
  assign out_ch.edit_note    = head.edit_note;

  // No event may enter while the step memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_accept)
    else $error("event accepted during step memory clear");

  // An accepted event reaches the step stage in the next cycle.
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> sb_valid)
    else $error("accepted event did not reach the step stage");

  // The step stage never pushes into a full queue that is not draining.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(sb_valid && q_cnt == OUTQ_CNT_W'(OUTQ_DEPTH) && !q_pop))
    else $error("result queue overflow");

  // With no result buffered and none in flight, the block accepts input
  // unless it is clearing.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == '0 && !sb_valid && !clr_busy) |-> in_ready)
    else $error("idle block refused input");

endmodule

`default_nettype wire
